FILE: sv/its_pkg.sv
// ----------------------------------------------------------------------------
// its_pkg: shared types and constants of the interpolated target sampler
// Operation, status and register codes, datapath widths, the sequencer state
// type and the request/response structs of the shared divider.
// ----------------------------------------------------------------------------
package its_pkg;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_LOAD_RATE   = 2'd0;
  localparam logic [1:0] OP_LOAD_DOMAIN = 2'd1;
  localparam logic [1:0] OP_QUERY       = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_BAD_SECTION = 2'd1;
  localparam logic [1:0] STATUS_BAD_INDEX   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RATE_MODE   = 2'd0;
  localparam logic [1:0] CFG_GRID_MIN    = 2'd1;
  localparam logic [1:0] CFG_GRID_STEP   = 2'd2;
  localparam logic [1:0] CFG_NODES_USED  = 2'd3;

  // Rate mode that selects the strict grid with per-target domain mask.
  localparam logic [1:0] MODE_STRICT = 2'd3;

  // Datapath widths, sized for up to sixteen targets.
  localparam int RATE_W = 32;   // one partial rate, Q16.16
  localparam int E_W    = 24;   // energy, Q16.8
  localparam int U_W    = 16;   // uniform fraction, Q0.16
  localparam int P_W    = 17;   // probability or alpha, Q0.16 up to 1.0
  localparam int WT_W   = 33;   // per-target weight
  localparam int SUM_W  = 37;   // sums of rates or weights
  localparam int MA_W   = 17;   // multiplier operand A
  localparam int MB_W   = 37;   // multiplier operand B
  localparam int MP_W   = 54;   // multiplier product
  localparam int ACC_W  = 53;   // total rate accumulator, Q21.32
  localparam int DVD_W  = 53;   // divider dividend
  localparam int DVS_W  = 37;   // divider divisor
  localparam int QUO_W  = 24;   // divider quotient
  localparam int QCNT_W = 5;    // divider quotient bit count

  localparam logic [P_W-1:0]    ONE16  = 17'h10000;
  localparam logic [QCNT_W-1:0] QB_IDX = 5'd24;
  localparam logic [QCNT_W-1:0] QB_FRC = 5'd17;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EMAX,
    ST_RANGE,
    ST_DIV_I0,
    ST_FRAC,
    ST_FRAC_W,
    ST_DIV_A,
    ST_M3_RD0,
    ST_M3_RD1,
    ST_M3_MUL1,
    ST_M3_ACC,
    ST_M1_SRD,
    ST_M1_SACC,
    ST_M1_TMUL,
    ST_M1_TACC,
    ST_M1_PRD,
    ST_M1_PCUM,
    ST_M1_PDIV,
    ST_M1_WMUL,
    ST_M1_WACC,
    ST_SRCH_MUL,
    ST_SRCH_UW,
    ST_SRCH,
    ST_PROB,
    ST_PDIV,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic              start;
    logic [QCNT_W-1:0] qbits;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: sv/its_ram.sv
// ----------------------------------------------------------------------------
// its_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module its_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/its_div.sv
// ----------------------------------------------------------------------------
// its_div: shared restoring divider
// Produces a quotient of qbits bits, one bit per cycle. The caller guarantees
// that the quotient fits, so the remainder starts from dividend >> qbits.
// ----------------------------------------------------------------------------
module its_div (
  input  logic               clk,
  input  logic               rst_n,
  input  its_pkg::div_req_t  req,
  output its_pkg::div_rsp_t  rsp
);

  logic                        run_r;
  logic                        done_r;
  logic [its_pkg::QCNT_W-1:0]  cnt_r;
  logic [its_pkg::DVS_W-1:0]   rem_r;
  logic [its_pkg::DVS_W-1:0]   dvs_r;
  logic [its_pkg::QUO_W-1:0]   lo_r;
  logic [its_pkg::QUO_W-1:0]   q_r;
  logic [its_pkg::DVS_W:0]     trial;
  logic [its_pkg::DVS_W:0]     diff;
  logic                        ge;

  assign trial = {rem_r, lo_r[its_pkg::QUO_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= req.qbits - 1'b1;
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= its_pkg::DVS_W'(req.dividend >> req.qbits);
      lo_r  <= its_pkg::QUO_W'(req.dividend << (its_pkg::QCNT_W'(its_pkg::QUO_W) - req.qbits));
      dvs_r <= req.divisor;
      q_r   <= '0;
    end else if (run_r) begin
      rem_r <= ge ? diff[its_pkg::DVS_W-1:0] : trial[its_pkg::DVS_W-1:0];
      lo_r  <= {lo_r[its_pkg::QUO_W-2:0], 1'b0};
      q_r   <= {q_r[its_pkg::QUO_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

FILE: sv/interpolated_target_sampler.sv
// ----------------------------------------------------------------------------
// interpolated_target_sampler: inverse-CDF target sampling with interpolation
// Loads partial rates and target domains, and answers sampling queries by
// linear interpolation between two energy nodes and a cumulative search.
// ----------------------------------------------------------------------------
// Loads and ignored operations: the result strobes in the cycle after the
// start transaction and busy never rises. The duration of a query is set
// by the one-bit-per-cycle shared divider and the single read port of the
// rate memory. One transaction is in flight at a time, and busy stays high
// until the result strobe. The receiver cannot stall. Reset (synchronous,
// active low) restores the control state, the configuration registers and
// the target domains at once; the rate memory holds no defined contents
// until it is written.
// ----------------------------------------------------------------------------
module interpolated_target_sampler #(
  parameter int NUM_SECTIONS     = 64,
  parameter int NUM_TARGETS      = 13,
  parameter int MAX_ENERGY_NODES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [5:0]  in_section,
  input  logic [3:0]  in_target,
  input  logic [8:0]  in_energy_node,
  input  logic [31:0] in_rate_value,
  input  logic [23:0] in_query_energy,
  input  logic [15:0] in_uniform_fraction,
  input  logic [23:0] in_domain_low,
  input  logic [23:0] in_domain_high,
  input  logic        in_domain_supported,
  // result side
  output logic        out_valid,
  output logic [3:0]  out_chosen_target,
  output logic [16:0] out_chosen_probability,
  output logic [35:0] out_total_rate,
  output logic [1:0]  out_status
);

  localparam int TGT_W  = $clog2(NUM_TARGETS);
  localparam int NODE_W = $clog2(MAX_ENERGY_NODES);
  localparam int CNT_W  = $clog2(MAX_ENERGY_NODES + 1);
  localparam int DEPTH  = NUM_SECTIONS * NUM_TARGETS * MAX_ENERGY_NODES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [TGT_W-1:0] LAST_K = TGT_W'(NUM_TARGETS - 1);

  // Configuration registers.
  logic [1:0]  mode_r;
  logic [23:0] gmin_r;
  logic [23:0] gstep_r;
  logic [9:0]  nodes_r;

  // Per-target domain stores, reset to the full energy range and supported.
  logic [23:0] dlo_r  [NUM_TARGETS];
  logic [23:0] dhi_r  [NUM_TARGETS];
  logic        dval_r [NUM_TARGETS];

  // Sequencer and datapath registers.
  its_pkg::st_t state_r, state_nxt;
  logic [TGT_W-1:0]          k_r, k_nxt;
  logic                      sel_r, sel_nxt;
  logic [5:0]                sec_r;
  logic [23:0]               e_r;
  logic [15:0]               u_r;
  logic [23:0]               d_r, d_nxt;
  logic [NODE_W-1:0]         i0_r, i0_nxt;
  logic [NODE_W-1:0]         i1_r, i1_nxt;
  logic [its_pkg::P_W-1:0]   alpha_r, alpha_nxt;
  logic [its_pkg::SUM_W-1:0] s_r, s_nxt;
  logic [its_pkg::SUM_W-1:0] cum_r, cum_nxt;
  logic [its_pkg::P_W-1:0]   prev_r, prev_nxt;
  logic [its_pkg::P_W-1:0]   p_r, p_nxt;
  logic [its_pkg::MP_W-1:0]  acc_r, acc_nxt;
  logic [its_pkg::ACC_W-1:0] tot_r, tot_nxt;
  logic [its_pkg::SUM_W-1:0] wsum_r, wsum_nxt;
  logic [its_pkg::ACC_W-1:0] uw_r, uw_nxt;
  logic [TGT_W-1:0]          chosen_r, chosen_nxt;
  logic [its_pkg::WT_W-1:0]  wsel_r, wsel_nxt;
  logic [its_pkg::P_W-1:0]   prob_r, prob_nxt;
  logic [its_pkg::MP_W-1:0]  mul_p_r;
  logic [its_pkg::WT_W-1:0]  w_r [NUM_TARGETS];
  logic                      w_we;
  logic [its_pkg::WT_W-1:0]  w_wdata;

  // Result registers.
  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  out_target_r, out_target_nxt;
  logic [16:0] out_prob_r, out_prob_nxt;
  logic [35:0] out_total_r, out_total_nxt;
  logic [1:0]  out_status_r, out_status_nxt;

  // Shared arithmetic.
  logic [its_pkg::MA_W-1:0] mul_a;
  logic [its_pkg::MB_W-1:0] mul_b;
  its_pkg::div_req_t        div_req;
  its_pkg::div_rsp_t        div_rsp;

  // Rate memory ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]       rdata;
  logic [NODE_W-1:0] node_rd;

  // Derived configuration values.
  logic [23:0]              step_eff;
  logic [CNT_W-1:0]         n_eff;
  logic [CNT_W-1:0]         nm1;
  logic [CNT_W-1:0]         nm2;
  logic [its_pkg::SUM_W-1:0] emax;
  logic                     strict;
  logic [its_pkg::P_W-1:0]  wt;

  // Decoded command.
  logic accept;
  logic sec_bad;
  logic tgt_bad;
  logic node_bad;

  // Per-step helpers.
  logic [23:0]               ec;
  logic [23:0]               q24;
  logic [CNT_W-1:0]          i0_c;
  logic [23:0]               frac;
  logic [its_pkg::MP_W:0]    m3_sum;
  logic [its_pkg::WT_W-1:0]  w_new;
  logic [its_pkg::P_W-1:0]   cq;
  logic                      masked;
  logic                      hit;

  assign accept   = start && !busy;
  assign busy     = (state_r != its_pkg::ST_IDLE);
  assign sec_bad  = (32'(in_section) >= NUM_SECTIONS);
  assign tgt_bad  = (32'(in_target) >= NUM_TARGETS);
  assign node_bad = (32'(in_energy_node) >= MAX_ENERGY_NODES);
  assign strict   = (mode_r == its_pkg::MODE_STRICT);
  assign step_eff = (gstep_r == 24'd0) ? 24'd1 : gstep_r;
  assign wt       = sel_r ? alpha_r : (its_pkg::ONE16 - alpha_r);

  // Node count is held inside [2, MAX_ENERGY_NODES].
  always_comb begin
    if (nodes_r < 10'd2) begin
      n_eff = CNT_W'(2);
    end else if (32'(nodes_r) > MAX_ENERGY_NODES) begin
      n_eff = CNT_W'(MAX_ENERGY_NODES);
    end else begin
      n_eff = CNT_W'(nodes_r);
    end
  end
  assign nm1 = n_eff - CNT_W'(1);
  assign nm2 = n_eff - CNT_W'(2);

  // The product (n-1)*step is waiting in the multiplier register during the
  // range check.
  assign emax = its_pkg::SUM_W'(gmin_r) + mul_p_r[its_pkg::SUM_W-1:0];

  // Rate memory: write straight from the command ports on an accepted load,
  // read at the section, target counter and selected node.
  assign ram_we    = accept && (in_operation == its_pkg::OP_LOAD_RATE) &&
                     !sec_bad && !tgt_bad && !node_bad;
  assign ram_waddr = (ADDR_W'(in_section) * ADDR_W'(NUM_TARGETS) + ADDR_W'(in_target)) *
                     ADDR_W'(MAX_ENERGY_NODES) + ADDR_W'(in_energy_node);
  assign node_rd   = ((state_r == its_pkg::ST_M3_RD1) || sel_r) ? i1_r : i0_r;
  assign ram_raddr = (ADDR_W'(sec_r) * ADDR_W'(NUM_TARGETS) + ADDR_W'(k_r)) *
                     ADDR_W'(MAX_ENERGY_NODES) + ADDR_W'(node_rd);

  its_ram #(
    .WIDTH (its_pkg::RATE_W),
    .DEPTH (DEPTH)
  ) u_rate_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_rate_value),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  its_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Helpers shared by the next-state and datapath blocks.
  always_comb begin
    // Legacy mode clamps the energy onto the grid.
    if (e_r < gmin_r) begin
      ec = gmin_r;
    end else if (its_pkg::SUM_W'(e_r) > emax) begin
      ec = emax[23:0];
    end else begin
      ec = e_r;
    end
    q24 = div_rsp.quotient;
    if (strict) begin
      i0_c = (q24 >= 24'(nm1)) ? nm2 : CNT_W'(q24);
    end else begin
      i0_c = (q24 > 24'(nm1)) ? nm1 : CNT_W'(q24);
    end
    frac    = d_r - mul_p_r[23:0];
    m3_sum  = {1'b0, acc_r} + {1'b0, mul_p_r};
    w_new   = (sel_r ? w_r[k_r] : '0) + mul_p_r[its_pkg::WT_W-1:0];
    cq      = div_rsp.quotient[its_pkg::P_W-1:0];
    masked  = !dval_r[k_r] || (e_r < dlo_r[k_r]) || (e_r > dhi_r[k_r]);
    cum_nxt = '0;
    case (state_r)
      its_pkg::ST_M1_PCUM: cum_nxt = cum_r + its_pkg::SUM_W'(rdata);
      its_pkg::ST_SRCH:    cum_nxt = cum_r + its_pkg::SUM_W'(w_r[k_r]);
      default:             cum_nxt = cum_r;
    endcase
    hit = uw_r < {cum_nxt, 16'd0};
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      its_pkg::ST_IDLE: begin
        if (accept && (in_operation == its_pkg::OP_QUERY) && !sec_bad) begin
          state_nxt = its_pkg::ST_EMAX;
        end
      end
      its_pkg::ST_EMAX:  state_nxt = its_pkg::ST_RANGE;
      its_pkg::ST_RANGE: begin
        if (strict && ((e_r < gmin_r) || (its_pkg::SUM_W'(e_r) > emax))) begin
          state_nxt = its_pkg::ST_DONE;
        end else begin
          state_nxt = its_pkg::ST_DIV_I0;
        end
      end
      its_pkg::ST_DIV_I0: if (div_rsp.done) state_nxt = its_pkg::ST_FRAC;
      its_pkg::ST_FRAC:   state_nxt = its_pkg::ST_FRAC_W;
      its_pkg::ST_FRAC_W: state_nxt = its_pkg::ST_DIV_A;
      its_pkg::ST_DIV_A: begin
        if (div_rsp.done) begin
          state_nxt = strict ? its_pkg::ST_M3_RD0 : its_pkg::ST_M1_SRD;
        end
      end
      its_pkg::ST_M3_RD0: begin
        if (!masked) begin
          state_nxt = its_pkg::ST_M3_RD1;
        end else if (k_r == LAST_K) begin
          state_nxt = its_pkg::ST_SRCH_MUL;
        end
      end
      its_pkg::ST_M3_RD1:  state_nxt = its_pkg::ST_M3_MUL1;
      its_pkg::ST_M3_MUL1: state_nxt = its_pkg::ST_M3_ACC;
      its_pkg::ST_M3_ACC: begin
        state_nxt = (k_r == LAST_K) ? its_pkg::ST_SRCH_MUL : its_pkg::ST_M3_RD0;
      end
      its_pkg::ST_M1_SRD:  state_nxt = its_pkg::ST_M1_SACC;
      its_pkg::ST_M1_SACC: begin
        state_nxt = (k_r == LAST_K) ? its_pkg::ST_M1_TMUL : its_pkg::ST_M1_SRD;
      end
      its_pkg::ST_M1_TMUL: state_nxt = its_pkg::ST_M1_TACC;
      its_pkg::ST_M1_TACC: state_nxt = its_pkg::ST_M1_PRD;
      its_pkg::ST_M1_PRD:  state_nxt = its_pkg::ST_M1_PCUM;
      its_pkg::ST_M1_PCUM: begin
        if ((s_r == '0) || (k_r == LAST_K)) begin
          state_nxt = its_pkg::ST_M1_WMUL;
        end else begin
          state_nxt = its_pkg::ST_M1_PDIV;
        end
      end
      its_pkg::ST_M1_PDIV: if (div_rsp.done) state_nxt = its_pkg::ST_M1_WMUL;
      its_pkg::ST_M1_WMUL: state_nxt = its_pkg::ST_M1_WACC;
      its_pkg::ST_M1_WACC: begin
        if (k_r != LAST_K) begin
          state_nxt = its_pkg::ST_M1_PRD;
        end else if (!sel_r) begin
          state_nxt = its_pkg::ST_M1_SRD;
        end else begin
          state_nxt = its_pkg::ST_SRCH_MUL;
        end
      end
      its_pkg::ST_SRCH_MUL: state_nxt = its_pkg::ST_SRCH_UW;
      its_pkg::ST_SRCH_UW:  state_nxt = its_pkg::ST_SRCH;
      its_pkg::ST_SRCH: begin
        if (hit || (k_r == LAST_K)) begin
          state_nxt = its_pkg::ST_PROB;
        end
      end
      its_pkg::ST_PROB: begin
        state_nxt = (wsum_r == '0) ? its_pkg::ST_DONE : its_pkg::ST_PDIV;
      end
      its_pkg::ST_PDIV: if (div_rsp.done) state_nxt = its_pkg::ST_DONE;
      its_pkg::ST_DONE: state_nxt = its_pkg::ST_IDLE;
      default:          state_nxt = its_pkg::ST_IDLE;
    endcase
  end

  // Datapath, shared-unit operands and results of each sequencer step.
  always_comb begin
    k_nxt      = k_r;
    sel_nxt    = sel_r;
    d_nxt      = d_r;
    i0_nxt     = i0_r;
    i1_nxt     = i1_r;
    alpha_nxt  = alpha_r;
    s_nxt      = s_r;
    prev_nxt   = prev_r;
    p_nxt      = p_r;
    acc_nxt    = acc_r;
    tot_nxt    = tot_r;
    wsum_nxt   = wsum_r;
    uw_nxt     = uw_r;
    chosen_nxt = chosen_r;
    wsel_nxt   = wsel_r;
    prob_nxt   = prob_r;
    w_we       = 1'b0;
    w_wdata    = w_new;
    mul_a      = '0;
    mul_b      = '0;
    div_req    = '0;

    out_valid_nxt  = 1'b0;
    out_target_nxt = out_target_r;
    out_prob_nxt   = out_prob_r;
    out_total_nxt  = out_total_r;
    out_status_nxt = out_status_r;

    case (state_r)
      its_pkg::ST_IDLE: begin
        if (accept) begin
          out_target_nxt = '0;
          out_prob_nxt   = '0;
          out_total_nxt  = '0;
          out_status_nxt = its_pkg::STATUS_OK;
          case (in_operation)
            its_pkg::OP_LOAD_RATE: begin
              out_valid_nxt = 1'b1;
              if (sec_bad) begin
                out_status_nxt = its_pkg::STATUS_BAD_SECTION;
              end else if (tgt_bad || node_bad) begin
                out_status_nxt = its_pkg::STATUS_BAD_INDEX;
              end
            end
            its_pkg::OP_LOAD_DOMAIN: begin
              out_valid_nxt = 1'b1;
              if (tgt_bad) begin
                out_status_nxt = its_pkg::STATUS_BAD_INDEX;
              end
            end
            its_pkg::OP_QUERY: begin
              if (sec_bad) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = its_pkg::STATUS_BAD_SECTION;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      its_pkg::ST_EMAX: begin
        mul_a = its_pkg::MA_W'(nm1);
        mul_b = its_pkg::MB_W'(step_eff);
      end
      its_pkg::ST_RANGE: begin
        if (strict && ((e_r < gmin_r) || (its_pkg::SUM_W'(e_r) > emax))) begin
          // Outside the grid in strict mode: every weight is zero.
          chosen_nxt = LAST_K;
          prob_nxt   = '0;
          tot_nxt    = '0;
        end else begin
          d_nxt            = (strict ? e_r : ec) - gmin_r;
          div_req.start    = 1'b1;
          div_req.qbits    = its_pkg::QB_IDX;
          div_req.dividend = its_pkg::DVD_W'(d_nxt);
          div_req.divisor  = its_pkg::DVS_W'(step_eff);
        end
      end
      its_pkg::ST_DIV_I0: begin
        if (div_rsp.done) begin
          i0_nxt = NODE_W'(i0_c);
          if (strict || (i0_c + CNT_W'(1) < nm1)) begin
            i1_nxt = NODE_W'(i0_c + CNT_W'(1));
          end else begin
            i1_nxt = NODE_W'(nm1);
          end
        end
      end
      its_pkg::ST_FRAC: begin
        mul_a = its_pkg::MA_W'(i0_r);
        mul_b = its_pkg::MB_W'(step_eff);
      end
      its_pkg::ST_FRAC_W: begin
        div_req.start    = 1'b1;
        div_req.qbits    = its_pkg::QB_FRC;
        div_req.dividend = its_pkg::DVD_W'({frac, 16'd0});
        div_req.divisor  = its_pkg::DVS_W'(step_eff);
      end
      its_pkg::ST_DIV_A: begin
        if (div_rsp.done) begin
          alpha_nxt = cq;
          k_nxt     = '0;
          sel_nxt   = 1'b0;
          s_nxt     = '0;
          tot_nxt   = '0;
          wsum_nxt  = '0;
        end
      end
      its_pkg::ST_M3_RD0: begin
        if (masked) begin
          w_we    = 1'b1;
          w_wdata = '0;
          if (k_r != LAST_K) begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      its_pkg::ST_M3_RD1: begin
        mul_a = its_pkg::ONE16 - alpha_r;
        mul_b = its_pkg::MB_W'(rdata);
      end
      its_pkg::ST_M3_MUL1: begin
        acc_nxt = mul_p_r;
        mul_a   = alpha_r;
        mul_b   = its_pkg::MB_W'(rdata);
      end
      its_pkg::ST_M3_ACC: begin
        w_we     = 1'b1;
        w_wdata  = m3_sum[its_pkg::WT_W+15:16];
        wsum_nxt = wsum_r + its_pkg::SUM_W'(m3_sum[its_pkg::WT_W+15:16]);
        tot_nxt  = tot_r + its_pkg::ACC_W'({m3_sum[its_pkg::WT_W+15:16], 16'd0});
        if (k_r != LAST_K) begin
          k_nxt = k_r + 1'b1;
        end
      end
      its_pkg::ST_M1_SACC: begin
        s_nxt = s_r + its_pkg::SUM_W'(rdata);
        k_nxt = (k_r == LAST_K) ? '0 : k_r + 1'b1;
      end
      its_pkg::ST_M1_TMUL: begin
        mul_a = wt;
        mul_b = s_r;
      end
      its_pkg::ST_M1_TACC: begin
        tot_nxt  = tot_r + mul_p_r[its_pkg::ACC_W-1:0];
        prev_nxt = '0;
      end
      its_pkg::ST_M1_PCUM: begin
        if (s_r == '0) begin
          p_nxt = '0;
        end else if (k_r == LAST_K) begin
          // The last cumulative value is forced to one.
          p_nxt = its_pkg::ONE16 - prev_r;
        end else begin
          div_req.start    = 1'b1;
          div_req.qbits    = its_pkg::QB_FRC;
          div_req.dividend = its_pkg::DVD_W'({cum_nxt, 16'd0});
          div_req.divisor  = s_r;
        end
      end
      its_pkg::ST_M1_PDIV: begin
        if (div_rsp.done) begin
          p_nxt    = (cq >= prev_r) ? cq - prev_r : '0;
          prev_nxt = cq;
        end
      end
      its_pkg::ST_M1_WMUL: begin
        mul_a = wt;
        mul_b = its_pkg::MB_W'(p_r);
      end
      its_pkg::ST_M1_WACC: begin
        w_we    = 1'b1;
        w_wdata = w_new;
        if (sel_r) begin
          wsum_nxt = wsum_r + its_pkg::SUM_W'(w_new);
        end
        if (k_r != LAST_K) begin
          k_nxt = k_r + 1'b1;
        end else if (!sel_r) begin
          sel_nxt = 1'b1;
          k_nxt   = '0;
          s_nxt   = '0;
        end
      end
      its_pkg::ST_SRCH_MUL: begin
        mul_a = its_pkg::MA_W'(u_r);
        mul_b = wsum_r;
      end
      its_pkg::ST_SRCH_UW: begin
        uw_nxt = mul_p_r[its_pkg::ACC_W-1:0];
        k_nxt  = '0;
      end
      its_pkg::ST_SRCH: begin
        if (hit || (k_r == LAST_K)) begin
          chosen_nxt = k_r;
          wsel_nxt   = w_r[k_r];
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      its_pkg::ST_PROB: begin
        if (wsum_r == '0) begin
          prob_nxt = '0;
        end else begin
          div_req.start    = 1'b1;
          div_req.qbits    = its_pkg::QB_FRC;
          div_req.dividend = its_pkg::DVD_W'({wsel_r, 16'd0});
          div_req.divisor  = wsum_r;
        end
      end
      its_pkg::ST_PDIV: begin
        if (div_rsp.done) begin
          prob_nxt = cq;
        end
      end
      its_pkg::ST_DONE: begin
        out_valid_nxt  = 1'b1;
        out_target_nxt = 4'(chosen_r);
        out_prob_nxt   = prob_r;
        out_total_nxt  = tot_r[51:16];
        out_status_nxt = its_pkg::STATUS_OK;
      end
      default: begin
      end
    endcase
  end

  // Control state, configuration registers and domain stores.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= its_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= 2'd1;
      gmin_r      <= 24'd0;
      gstep_r     <= 24'd256;
      nodes_r     <= 10'd512;
      for (int i = 0; i < NUM_TARGETS; i++) begin
        dlo_r[i]  <= 24'd0;
        dhi_r[i]  <= 24'hFFFFFF;
        dval_r[i] <= 1'b1;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          its_pkg::CFG_RATE_MODE:  mode_r  <= cfg_wdata[1:0];
          its_pkg::CFG_GRID_MIN:   gmin_r  <= cfg_wdata;
          its_pkg::CFG_GRID_STEP:  gstep_r <= cfg_wdata;
          its_pkg::CFG_NODES_USED: nodes_r <= cfg_wdata[9:0];
          default: begin
          end
        endcase
      end
      if (accept && (in_operation == its_pkg::OP_LOAD_DOMAIN) && !tgt_bad) begin
        dlo_r[in_target[TGT_W-1:0]]  <= in_domain_low;
        dhi_r[in_target[TGT_W-1:0]]  <= in_domain_high;
        dval_r[in_target[TGT_W-1:0]] <= in_domain_supported;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      sec_r <= in_section;
      e_r   <= in_query_energy;
      u_r   <= in_uniform_fraction;
    end
    k_r      <= k_nxt;
    sel_r    <= sel_nxt;
    d_r      <= d_nxt;
    i0_r     <= i0_nxt;
    i1_r     <= i1_nxt;
    alpha_r  <= alpha_nxt;
    s_r      <= s_nxt;
    cum_r    <= (state_r == its_pkg::ST_M1_TACC || state_r == its_pkg::ST_SRCH_UW) ?
                '0 : cum_nxt;
    prev_r   <= prev_nxt;
    p_r      <= p_nxt;
    acc_r    <= acc_nxt;
    tot_r    <= tot_nxt;
    wsum_r   <= wsum_nxt;
    uw_r     <= uw_nxt;
    chosen_r <= chosen_nxt;
    wsel_r   <= wsel_nxt;
    prob_r   <= prob_nxt;
    mul_p_r  <= mul_a * mul_b;
    if (w_we) begin
      w_r[k_r] <= w_wdata;
    end
    out_target_r <= out_target_nxt;
    out_prob_r   <= out_prob_nxt;
    out_total_r  <= out_total_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_chosen_target      = out_target_r;
  assign out_chosen_probability = out_prob_r;
  assign out_total_rate         = out_total_r;
  assign out_status             = out_status_r;

endmodule

FILE: sv/its_chk.sv
// ----------------------------------------------------------------------------
// its_chk: port-level checker of the interpolated target sampler
// Watches transactions on the command and result ports.
// ----------------------------------------------------------------------------
module its_chk #(
  parameter int NUM_SECTIONS = 64,
  parameter int NUM_TARGETS  = 13
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_operation,
  input logic [5:0]  in_section,
  input logic        out_valid,
  input logic [3:0]  out_chosen_target,
  input logic [16:0] out_chosen_probability,
  input logic [35:0] out_total_rate,
  input logic [1:0]  out_status
);

  // A load transaction is answered in the next cycle with zero payload.
  a_load_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation == its_pkg::OP_LOAD_RATE ||
                        in_operation == its_pkg::OP_LOAD_DOMAIN))
    |=> (out_valid && out_total_rate == 36'd0 && out_chosen_probability == 17'd0 &&
         out_chosen_target == 4'd0))
    else $error("load transaction not answered with zero payload");

  // A query on a valid section keeps the block busy.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == its_pkg::OP_QUERY &&
     32'(in_section) < NUM_SECTIONS) |=> busy)
    else $error("query accepted without going busy");

  // An error status carries no sample.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != its_pkg::STATUS_OK)
    |-> (out_total_rate == 36'd0 && out_chosen_probability == 17'd0 &&
         out_chosen_target == 4'd0))
    else $error("error result carries a sample");

  // Results stay in range.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_chosen_probability <= 17'h10000 &&
                   32'(out_chosen_target) < NUM_TARGETS))
    else $error("result out of range");

  // The end of a query always comes with its result.
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("query finished without a result");

endmodule

bind interpolated_target_sampler its_chk #(
  .NUM_SECTIONS (NUM_SECTIONS),
  .NUM_TARGETS  (NUM_TARGETS)
) u_its_chk (.*);
